// ===== hdl/vector3_normalize_unit_defines.svh =====
// Assertion macros shared by the vector normalize RTL
`ifndef VECTOR3_NORMALIZE_UNIT_DEFINES_SVH
`define VECTOR3_NORMALIZE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while arst_n is low
`define V3N_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Delayed implication, checked on clk, off while arst_n is low
`define V3N_ASSERT_DELAY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##(dly) (cons)) else $error(msg);

`endif

// ===== hdl/v3n_pkg.sv =====
// Package: widths, stage bundles and constants of the vector normalize pipeline
`timescale 1ns / 1ps
`default_nettype none

package v3n_pkg;

	// Input component width (signed Q8.8) and output fraction bits
	localparam int IN_WIDTH      = 16;
	localparam int OUT_FRAC_BITS = 14;

	// Derived widths
	localparam int OUT_W  = OUT_FRAC_BITS + 2;       // signed Q1.F result
	localparam int Q_W    = OUT_FRAC_BITS + 1;       // quotient magnitude, up to 1.0
	localparam int SQ_W   = 2 * IN_WIDTH;            // one squared magnitude
	localparam int SUM_W  = SQ_W + 2;                // sum of three squares
	localparam int T_W    = SQ_W + 2 * OUT_FRAC_BITS; // scaled square, search target
	localparam int R_W    = Q_W + SUM_W;             // running q * S
	localparam int CMP_W  = R_W + Q_W + 1;           // trial subtrahend

	localparam int NUM_LANES = 3;
	localparam int NUM_STEPS = Q_W;                   // one quotient bit per stage

	// start cycle to done cycle: three front stages, the bit stages, the output stage
	localparam int LATENCY = NUM_STEPS + 4;

	localparam logic [Q_W-1:0] UNIT_ONE_Q = Q_W'(1) << OUT_FRAC_BITS;
	localparam int UNIT_ONE = 1 << OUT_FRAC_BITS;

	// Per-component search state
	typedef struct packed {
		logic [T_W-1:0] rem;   // target minus q*q*S
		logic [R_W-1:0] qs;    // q * S
		logic [Q_W-1:0] q;     // quotient bits found so far
		logic           neg;   // component sign
	} lane_t;

	// One item as it moves through the bit stages
	typedef struct packed {
		logic                          zero;
		logic [SUM_W-1:0]              sum;
		lane_t [NUM_LANES-1:0]         lanes;
	} item_t;

endpackage

`default_nettype wire

// ===== hdl/v3n_front.sv =====
// Front stages: magnitudes, squares, sum of squares and search targets
`timescale 1ns / 1ps
`default_nettype none

module v3n_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]  comp_x,
	input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]  comp_y,
	input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]  comp_z,
	output logic                                      out_valid,
	output v3n_pkg::item_t                            out_item
);

	logic [v3n_pkg::IN_WIDTH-1:0] comp [v3n_pkg::NUM_LANES];

	logic                         valid_s1, valid_s2, valid_s3;
	logic [v3n_pkg::IN_WIDTH-1:0] mag_s1 [v3n_pkg::NUM_LANES];
	logic                         neg_s1 [v3n_pkg::NUM_LANES];
	logic [v3n_pkg::SQ_W-1:0]     sq_s2  [v3n_pkg::NUM_LANES];
	logic                         neg_s2 [v3n_pkg::NUM_LANES];
	v3n_pkg::item_t               item_s3;

	assign comp[0] = comp_x;
	assign comp[1] = comp_y;
	assign comp[2] = comp_z;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// s1: sign and magnitude; the most negative code gives 2^(IN_WIDTH-1)
	always_ff @(posedge clk) begin
		for (int i = 0; i < v3n_pkg::NUM_LANES; i++) begin
			neg_s1[i] <= comp[i][v3n_pkg::IN_WIDTH-1];
			mag_s1[i] <= comp[i][v3n_pkg::IN_WIDTH-1]
				? (~comp[i] + v3n_pkg::IN_WIDTH'(1)) : comp[i];
		end
	end

	// s2: squares
	always_ff @(posedge clk) begin
		for (int i = 0; i < v3n_pkg::NUM_LANES; i++) begin
			neg_s2[i] <= neg_s1[i];
			sq_s2[i]  <= v3n_pkg::SQ_W'(mag_s1[i]) * v3n_pkg::SQ_W'(mag_s1[i]);
		end
	end

	// s3: sum of squares and per-lane target c*c*2^(2F)
	always_ff @(posedge clk) begin
		item_s3.sum  <= v3n_pkg::SUM_W'(sq_s2[0]) + v3n_pkg::SUM_W'(sq_s2[1])
			+ v3n_pkg::SUM_W'(sq_s2[2]);
		item_s3.zero <= (sq_s2[0] == '0) && (sq_s2[1] == '0) && (sq_s2[2] == '0);
		for (int i = 0; i < v3n_pkg::NUM_LANES; i++) begin
			item_s3.lanes[i].rem <= v3n_pkg::T_W'(sq_s2[i]) << (2 * v3n_pkg::OUT_FRAC_BITS);
			item_s3.lanes[i].qs  <= '0;
			item_s3.lanes[i].q   <= '0;
			item_s3.lanes[i].neg <= neg_s2[i];
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

`default_nettype wire

// ===== hdl/v3n_div_pipe.sv =====
// Bit stages: restoring search for floor(c * 2^F / sqrt(S)), one bit per stage
`timescale 1ns / 1ps
`default_nettype none

module v3n_div_pipe (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire v3n_pkg::item_t in_item,
	output logic                out_valid,
	output v3n_pkg::item_t      out_item
);

	// stage registers, index k is bit stage k
	logic           valid_sn [v3n_pkg::NUM_STEPS];
	v3n_pkg::item_t item_sn  [v3n_pkg::NUM_STEPS];

	for (genvar k = 0; k < v3n_pkg::NUM_STEPS; k++) begin : g_step
		localparam int BIT = v3n_pkg::OUT_FRAC_BITS - k;

		logic                        stage_valid;
		v3n_pkg::item_t              stage_in, stage_nxt;
		logic [v3n_pkg::CMP_W-1:0]   sub  [v3n_pkg::NUM_LANES];
		logic [v3n_pkg::CMP_W:0]     diff [v3n_pkg::NUM_LANES];

		if (k == 0) begin : g_first
			assign stage_valid = in_valid;
			assign stage_in    = in_item;
		end else begin : g_next
			assign stage_valid = valid_sn[k-1];
			assign stage_in    = item_sn[k-1];
		end

		// trial t = q | 2^b: t*t*S - q*q*S = (q*S) << (b+1) + S << 2b
		always_comb begin
			stage_nxt = stage_in;
			for (int i = 0; i < v3n_pkg::NUM_LANES; i++) begin
				sub[i] = (v3n_pkg::CMP_W'(stage_in.lanes[i].qs) << (BIT + 1))
					+ (v3n_pkg::CMP_W'(stage_in.sum) << (2 * BIT));
				diff[i] = {1'b0, v3n_pkg::CMP_W'(stage_in.lanes[i].rem)} - {1'b0, sub[i]};
				if (!diff[i][v3n_pkg::CMP_W]) begin
					stage_nxt.lanes[i].rem = diff[i][v3n_pkg::T_W-1:0];
					stage_nxt.lanes[i].q   = stage_in.lanes[i].q
						| (v3n_pkg::Q_W'(1) << BIT);
					stage_nxt.lanes[i].qs  = stage_in.lanes[i].qs
						+ (v3n_pkg::R_W'(stage_in.sum) << BIT);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k] <= 1'b0;
			end else begin
				valid_sn[k] <= stage_valid;
			end
		end

		always_ff @(posedge clk) begin
			item_sn[k] <= stage_nxt;
		end
	end

	assign out_valid = valid_sn[v3n_pkg::NUM_STEPS-1];
	assign out_item  = item_sn[v3n_pkg::NUM_STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/v3n_back.sv =====
// Output stage: clamp to 1.0, apply sign, zero vector override, result registers
`timescale 1ns / 1ps
`default_nettype none

module v3n_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire v3n_pkg::item_t                     in_item,
	output logic                                    done,
	output logic signed [v3n_pkg::OUT_W-1:0]        unit_x,
	output logic signed [v3n_pkg::OUT_W-1:0]        unit_y,
	output logic signed [v3n_pkg::OUT_W-1:0]        unit_z,
	output logic                                    zero_length
);

	logic                       done_q;
	logic                       zero_q;
	logic [v3n_pkg::OUT_W-1:0]  unit_q   [v3n_pkg::NUM_LANES];
	logic [v3n_pkg::OUT_W-1:0]  unit_nxt [v3n_pkg::NUM_LANES];
	logic [v3n_pkg::Q_W-1:0]    mag_cl   [v3n_pkg::NUM_LANES];

	// clamp, then two's complement for negative components; zeros for a zero vector
	always_comb begin
		for (int i = 0; i < v3n_pkg::NUM_LANES; i++) begin
			mag_cl[i] = (in_item.lanes[i].q > v3n_pkg::UNIT_ONE_Q)
				? v3n_pkg::UNIT_ONE_Q : in_item.lanes[i].q;
			if (in_item.zero) begin
				unit_nxt[i] = '0;
			end else if (in_item.lanes[i].neg) begin
				unit_nxt[i] = ~v3n_pkg::OUT_W'(mag_cl[i]) + v3n_pkg::OUT_W'(1);
			end else begin
				unit_nxt[i] = v3n_pkg::OUT_W'(mag_cl[i]);
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		zero_q <= in_item.zero;
		for (int i = 0; i < v3n_pkg::NUM_LANES; i++) begin
			unit_q[i] <= unit_nxt[i];
		end
	end

	assign done        = done_q;
	assign zero_length = zero_q;
	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];

endmodule

`default_nettype wire

// ===== hdl/vector3_normalize_unit.sv =====
// Top level: 3D vector normalizer, signed Q8.8 in, signed Q1.14 out
//
// Usage:
//   Drive comp_x, comp_y, comp_z and raise start for one cycle per vector.
//   An item is taken at each rising edge with start high and busy low; busy
//   is always low, so a new vector can be taken in every cycle.
//   Each result shows on unit_x, unit_y, unit_z and zero_length for exactly
//   one cycle with done high; the receiver must take it then.
//   The pipeline depth is set by the quotient search: one bit stage per
//   result bit, three lanes side by side, plus three front stages and an
//   output stage. Throughput: one vector per cycle.
//   Results are in order, truncated toward zero and limited to +/-1.0.
//   A zero vector gives zeros with zero_length high.
//   Reset (arst_n low) drops every item in flight; no result follows it.
`timescale 1ns / 1ps
`default_nettype none

`include "vector3_normalize_unit_defines.svh"

module vector3_normalize_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]  comp_x,
	input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]  comp_y,
	input  wire logic signed [v3n_pkg::IN_WIDTH-1:0]  comp_z,
	output logic                                      done,
	output logic signed [v3n_pkg::OUT_W-1:0]          unit_x,
	output logic signed [v3n_pkg::OUT_W-1:0]          unit_y,
	output logic signed [v3n_pkg::OUT_W-1:0]          unit_z,
	output logic                                      zero_length
);

	logic           take;
	logic           front_valid, div_valid;
	v3n_pkg::item_t front_item, div_item;

	// fully pipelined, never holds off the sender
	assign busy = 1'b0;
	assign take = start && !busy;

	v3n_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take),
		.comp_x    (comp_x),
		.comp_y    (comp_y),
		.comp_z    (comp_z),
		.out_valid (front_valid),
		.out_item  (front_item)
	);

	v3n_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_item   (front_item),
		.out_valid (div_valid),
		.out_item  (div_item)
	);

	v3n_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.in_item     (div_item),
		.done        (done),
		.unit_x      (unit_x),
		.unit_y      (unit_y),
		.unit_z      (unit_z),
		.zero_length (zero_length)
	);

	// every taken item yields a result with done high, delayed by LATENCY
	`V3N_ASSERT_DELAY(a_latency, take, v3n_pkg::LATENCY, done, "result missing after latency")
	// a zero vector gives all-zero components
	`V3N_ASSERT_NOW(a_zero_out, done && zero_length, unit_x == 0 && unit_y == 0 && unit_z == 0, "zero vector gave nonzero output")
	// results stay within plus or minus 1.0
	`V3N_ASSERT_NOW(a_range_x, done, unit_x <= v3n_pkg::UNIT_ONE && unit_x >= -v3n_pkg::UNIT_ONE, "unit_x out of range")
	`V3N_ASSERT_NOW(a_range_y, done, unit_y <= v3n_pkg::UNIT_ONE && unit_y >= -v3n_pkg::UNIT_ONE, "unit_y out of range")
	`V3N_ASSERT_NOW(a_range_z, done, unit_z <= v3n_pkg::UNIT_ONE && unit_z >= -v3n_pkg::UNIT_ONE, "unit_z out of range")

endmodule

`default_nettype wire
